FILE: hdl/jsd_pkg.sv
`default_nettype none

package jsd_pkg;

    // result kinds
    localparam logic [1:0] RK_CP  = 2'd0;
    localparam logic [1:0] RK_END = 2'd1;
    localparam logic [1:0] RK_ERR = 2'd2;

    // characters the decoder looks for
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    localparam logic [7:0] CTRL_LF  = 8'h0A;
    localparam logic [7:0] CTRL_CR  = 8'h0D;
    localparam logic [7:0] CTRL_TAB = 8'h09;
    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_FF  = 8'h0C;

    // surrogate prefixes on bits 15:10 of a \u value
    localparam logic [5:0] SURR_HIGH = 6'b110110;
    localparam logic [5:0] SURR_LOW  = 6'b110111;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_BODY   = 3'd1,
        MODE_ESC    = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_HIWAIT = 3'd4,
        MODE_HIESC  = 3'd5,
        MODE_HIHEX  = 3'd6,
        MODE_UTF8   = 3'd7
    } mode_t;

    typedef enum logic [3:0] {
        ACT_FAIL,
        ACT_OPEN,
        ACT_BODY,
        ACT_ESC,
        ACT_HEXSTEP,
        ACT_PLAIN,
        ACT_PAIR,
        ACT_HIESC,
        ACT_HIHEX,
        ACT_UTF8STEP
    } act_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [20:0] cp;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } step_t;

endpackage

`default_nettype wire

FILE: hdl/jsd_in_if.sv
`default_nettype none

interface jsd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/jsd_out_if.sv
`default_nettype none

interface jsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [20:0] code_point;
    logic        last;

    modport source (output valid, output result_kind, output code_point, output last,
                    input ready);
    modport sink   (input valid, input result_kind, input code_point, input last,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/jsd_core.sv
`default_nettype none

module jsd_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            commit,
    input  logic            kind,
    input  logic [7:0]      data_byte,
    output jsd_pkg::step_t  step
);

    jsd_pkg::mode_t mode_reg, mode_next;
    logic [1:0]  digit_count_reg, digit_count_next;
    logic [20:0] acc_reg, acc_next;
    logic [1:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  lead_byte_reg, lead_byte_next;
    logic [9:0]  pending_high_reg, pending_high_next;

    // byte classification
    logic        hex_ok;
    logic [3:0]  hex_digit;
    logic        esc_ok;
    logic [7:0]  esc_val;
    logic        is_lead2, is_lead3, is_lead4, is_cont;
    logic [15:0] acc16;
    logic [20:0] utf8_acc;
    logic [20:0] high_cp;
    logic [20:0] pair_cp;
    logic        pre_high, pre_lead;
    jsd_pkg::act_t act;

    logic        main_valid;
    logic [1:0]  main_kind;
    logic [20:0] main_cp;

    always_comb
    begin
        hex_ok    = 1'b1;
        hex_digit = data_byte[3:0];
        if (data_byte >= 8'h30 && data_byte <= 8'h39)
        begin
            hex_digit = data_byte[3:0];
        end
        else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                 (data_byte >= 8'h41 && data_byte <= 8'h46))
        begin
            hex_digit = data_byte[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    always_comb
    begin
        esc_ok  = 1'b1;
        esc_val = data_byte;
        case (data_byte)
            jsd_pkg::CH_QUOTE:  esc_val = jsd_pkg::CH_QUOTE;
            jsd_pkg::CH_BSLASH: esc_val = jsd_pkg::CH_BSLASH;
            jsd_pkg::CH_SLASH:  esc_val = jsd_pkg::CH_SLASH;
            jsd_pkg::CH_LOW_N:  esc_val = jsd_pkg::CTRL_LF;
            jsd_pkg::CH_LOW_R:  esc_val = jsd_pkg::CTRL_CR;
            jsd_pkg::CH_LOW_T:  esc_val = jsd_pkg::CTRL_TAB;
            jsd_pkg::CH_LOW_B:  esc_val = jsd_pkg::CTRL_BS;
            jsd_pkg::CH_LOW_F:  esc_val = jsd_pkg::CTRL_FF;
            default:            esc_ok  = 1'b0;
        endcase
    end

    assign is_lead2 = (data_byte[7:5] == 3'b110);
    assign is_lead3 = (data_byte[7:4] == 4'b1110);
    assign is_lead4 = (data_byte[7:3] == 5'b11110);
    assign is_cont  = (data_byte[7:6] == 2'b10);
    assign acc16    = {acc_reg[11:0], hex_digit};
    assign utf8_acc = {acc_reg[14:0], data_byte[5:0]};
    assign high_cp  = {5'd0, jsd_pkg::SURR_HIGH, pending_high_reg};
    assign pair_cp  = jsd_pkg::SUPP_BASE + {1'b0, pending_high_reg, acc16[9:0]};

    // what this word does, and whether a held code point goes out first
    always_comb
    begin
        pre_high = 1'b0;
        pre_lead = 1'b0;
        act      = jsd_pkg::ACT_FAIL;
        if (kind)
        begin
            pre_high = (mode_reg == jsd_pkg::MODE_HIWAIT) ||
                       (mode_reg == jsd_pkg::MODE_HIESC) ||
                       (mode_reg == jsd_pkg::MODE_HIHEX);
            pre_lead = (mode_reg == jsd_pkg::MODE_UTF8);
            act      = jsd_pkg::ACT_FAIL;
        end
        else
        begin
            case (mode_reg)
                jsd_pkg::MODE_IDLE:
                begin
                    act = (data_byte == jsd_pkg::CH_QUOTE) ? jsd_pkg::ACT_OPEN
                                                           : jsd_pkg::ACT_FAIL;
                end
                jsd_pkg::MODE_BODY:
                begin
                    act = jsd_pkg::ACT_BODY;
                end
                jsd_pkg::MODE_ESC:
                begin
                    act = jsd_pkg::ACT_ESC;
                end
                jsd_pkg::MODE_HEX, jsd_pkg::MODE_HIHEX:
                begin
                    if (!hex_ok)
                    begin
                        pre_high = (mode_reg == jsd_pkg::MODE_HIHEX);
                        act      = jsd_pkg::ACT_FAIL;
                    end
                    else if (digit_count_reg != 2'd3)
                    begin
                        act = jsd_pkg::ACT_HEXSTEP;
                    end
                    else if (mode_reg == jsd_pkg::MODE_HEX)
                    begin
                        act = jsd_pkg::ACT_PLAIN;
                    end
                    else if (acc16[15:10] == jsd_pkg::SURR_LOW)
                    begin
                        act = jsd_pkg::ACT_PAIR;
                    end
                    else
                    begin
                        pre_high = 1'b1;
                        act      = jsd_pkg::ACT_PLAIN;
                    end
                end
                jsd_pkg::MODE_HIWAIT:
                begin
                    if (data_byte == jsd_pkg::CH_BSLASH)
                    begin
                        act = jsd_pkg::ACT_HIESC;
                    end
                    else
                    begin
                        pre_high = 1'b1;
                        act      = jsd_pkg::ACT_BODY;
                    end
                end
                jsd_pkg::MODE_HIESC:
                begin
                    if (data_byte == jsd_pkg::CH_LOW_U)
                    begin
                        act = jsd_pkg::ACT_HIHEX;
                    end
                    else
                    begin
                        pre_high = 1'b1;
                        act      = jsd_pkg::ACT_ESC;
                    end
                end
                jsd_pkg::MODE_UTF8:
                begin
                    if (!is_cont)
                    begin
                        pre_lead = 1'b1;
                        act      = jsd_pkg::ACT_BODY;
                    end
                    else
                    begin
                        act = jsd_pkg::ACT_UTF8STEP;
                    end
                end
                default:
                begin
                    act = jsd_pkg::ACT_FAIL;
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        mode_next         = mode_reg;
        digit_count_next  = digit_count_reg;
        acc_next          = acc_reg;
        bytes_left_next   = bytes_left_reg;
        lead_byte_next    = lead_byte_reg;
        pending_high_next = pending_high_reg;
        case (act)
            jsd_pkg::ACT_FAIL:
            begin
                mode_next         = jsd_pkg::MODE_IDLE;
                digit_count_next  = 2'd0;
                acc_next          = 21'd0;
                bytes_left_next   = 2'd0;
                lead_byte_next    = 8'd0;
                pending_high_next = 10'd0;
            end
            jsd_pkg::ACT_OPEN:
            begin
                mode_next = jsd_pkg::MODE_BODY;
            end
            jsd_pkg::ACT_BODY:
            begin
                mode_next = jsd_pkg::MODE_BODY;
                if (pre_lead)
                begin
                    acc_next        = 21'd0;
                    bytes_left_next = 2'd0;
                end
                if (data_byte == jsd_pkg::CH_QUOTE)
                begin
                    mode_next         = jsd_pkg::MODE_IDLE;
                    digit_count_next  = 2'd0;
                    acc_next          = 21'd0;
                    bytes_left_next   = 2'd0;
                    lead_byte_next    = 8'd0;
                    pending_high_next = 10'd0;
                end
                else if (data_byte == jsd_pkg::CH_BSLASH)
                begin
                    mode_next = jsd_pkg::MODE_ESC;
                end
                else if (is_lead2 || is_lead3 || is_lead4)
                begin
                    mode_next      = jsd_pkg::MODE_UTF8;
                    lead_byte_next = data_byte;
                    if (is_lead2)
                    begin
                        bytes_left_next = 2'd1;
                        acc_next        = {16'd0, data_byte[4:0]};
                    end
                    else if (is_lead3)
                    begin
                        bytes_left_next = 2'd2;
                        acc_next        = {17'd0, data_byte[3:0]};
                    end
                    else
                    begin
                        bytes_left_next = 2'd3;
                        acc_next        = {18'd0, data_byte[2:0]};
                    end
                end
            end
            jsd_pkg::ACT_ESC:
            begin
                if (data_byte == jsd_pkg::CH_LOW_U)
                begin
                    mode_next        = jsd_pkg::MODE_HEX;
                    digit_count_next = 2'd0;
                    acc_next         = 21'd0;
                end
                else if (esc_ok)
                begin
                    mode_next = jsd_pkg::MODE_BODY;
                end
                else
                begin
                    mode_next         = jsd_pkg::MODE_IDLE;
                    digit_count_next  = 2'd0;
                    acc_next          = 21'd0;
                    bytes_left_next   = 2'd0;
                    lead_byte_next    = 8'd0;
                    pending_high_next = 10'd0;
                end
            end
            jsd_pkg::ACT_HEXSTEP:
            begin
                acc_next         = {5'd0, acc16};
                digit_count_next = digit_count_reg + 2'd1;
            end
            jsd_pkg::ACT_PLAIN:
            begin
                acc_next         = 21'd0;
                digit_count_next = 2'd0;
                if (acc16[15:10] == jsd_pkg::SURR_HIGH)
                begin
                    pending_high_next = acc16[9:0];
                    mode_next         = jsd_pkg::MODE_HIWAIT;
                end
                else
                begin
                    mode_next = jsd_pkg::MODE_BODY;
                end
            end
            jsd_pkg::ACT_PAIR:
            begin
                mode_next        = jsd_pkg::MODE_BODY;
                acc_next         = 21'd0;
                digit_count_next = 2'd0;
            end
            jsd_pkg::ACT_HIESC:
            begin
                mode_next = jsd_pkg::MODE_HIESC;
            end
            jsd_pkg::ACT_HIHEX:
            begin
                mode_next        = jsd_pkg::MODE_HIHEX;
                digit_count_next = 2'd0;
                acc_next         = 21'd0;
            end
            jsd_pkg::ACT_UTF8STEP:
            begin
                bytes_left_next = bytes_left_reg - 2'd1;
                if (bytes_left_reg == 2'd1)
                begin
                    mode_next = jsd_pkg::MODE_BODY;
                    acc_next  = 21'd0;
                end
                else
                begin
                    acc_next = utf8_acc;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // results of this word
    always_comb
    begin
        main_valid = 1'b0;
        main_kind  = jsd_pkg::RK_CP;
        main_cp    = 21'd0;
        case (act)
            jsd_pkg::ACT_FAIL:
            begin
                main_valid = 1'b1;
                main_kind  = jsd_pkg::RK_ERR;
            end
            jsd_pkg::ACT_BODY:
            begin
                if (data_byte == jsd_pkg::CH_QUOTE)
                begin
                    main_valid = 1'b1;
                    main_kind  = jsd_pkg::RK_END;
                end
                else if (!(data_byte == jsd_pkg::CH_BSLASH || is_lead2 || is_lead3 ||
                           is_lead4))
                begin
                    main_valid = 1'b1;
                    main_cp    = {13'd0, data_byte};
                end
            end
            jsd_pkg::ACT_ESC:
            begin
                if (data_byte != jsd_pkg::CH_LOW_U)
                begin
                    main_valid = 1'b1;
                    if (esc_ok)
                    begin
                        main_cp = {13'd0, esc_val};
                    end
                    else
                    begin
                        main_kind = jsd_pkg::RK_ERR;
                    end
                end
            end
            jsd_pkg::ACT_PLAIN:
            begin
                if (acc16[15:10] != jsd_pkg::SURR_HIGH)
                begin
                    main_valid = 1'b1;
                    main_cp    = {5'd0, acc16};
                end
            end
            jsd_pkg::ACT_PAIR:
            begin
                main_valid = 1'b1;
                main_cp    = pair_cp;
            end
            jsd_pkg::ACT_UTF8STEP:
            begin
                if (bytes_left_reg == 2'd1)
                begin
                    main_valid = 1'b1;
                    main_cp    = utf8_acc;
                end
            end
            default:
            begin
                main_valid = 1'b0;
            end
        endcase

        step = '0;
        if (pre_high || pre_lead)
        begin
            step.res0.kind = jsd_pkg::RK_CP;
            step.res0.cp   = pre_high ? high_cp : {13'd0, lead_byte_reg};
            step.res0.last = !main_valid;
            step.res1.kind = main_kind;
            step.res1.cp   = main_cp;
            step.res1.last = 1'b1;
            step.count     = main_valid ? 2'd2 : 2'd1;
        end
        else
        begin
            step.res0.kind = main_kind;
            step.res0.cp   = main_cp;
            step.res0.last = 1'b1;
            step.count     = main_valid ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= jsd_pkg::MODE_IDLE;
            digit_count_reg  <= 2'd0;
            acc_reg          <= 21'd0;
            bytes_left_reg   <= 2'd0;
            lead_byte_reg    <= 8'd0;
            pending_high_reg <= 10'd0;
        end
        else if (commit)
        begin
            mode_reg         <= mode_next;
            digit_count_reg  <= digit_count_next;
            acc_reg          <= acc_next;
            bytes_left_reg   <= bytes_left_next;
            lead_byte_reg    <= lead_byte_next;
            pending_high_reg <= pending_high_next;
        end
    end

    a_end_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        commit && kind |=> mode_reg == jsd_pkg::MODE_IDLE)
        else $error("end of input did not return the decoder to idle");

    a_end_gives_error: assert property (@(posedge clk) disable iff (!rst_n)
        commit && kind |->
            (step.count == 2'd1 && step.res0.kind == jsd_pkg::RK_ERR) ||
            (step.count == 2'd2 && step.res1.kind == jsd_pkg::RK_ERR))
        else $error("end of input without a final error result");

    a_utf8_has_bytes_left: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == jsd_pkg::MODE_UTF8 |-> bytes_left_reg != 2'd0)
        else $error("utf-8 sequence in progress with no continuation bytes left");

endmodule

`default_nettype wire

FILE: hdl/jsd_queue.sv
`default_nettype none

module jsd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jsd_pkg::step_t  step,
    output logic            room,
    jsd_out_if.source       result
);

    jsd_pkg::result_t entry_reg [jsd_pkg::QUEUE_DEPTH];
    logic [jsd_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [jsd_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [jsd_pkg::QUEUE_CW-1:0] count_reg, count_next;
    logic [jsd_pkg::QUEUE_CW-1:0] push_n;
    logic pop;

    assign pop    = result.valid && result.ready;
    assign push_n = push ? jsd_pkg::QUEUE_CW'(step.count) : '0;
    assign room   = (count_reg <= jsd_pkg::QUEUE_CW'(jsd_pkg::QUEUE_DEPTH - 2));

    assign result.valid       = (count_reg != '0);
    assign result.result_kind = entry_reg[rd_ptr_reg].kind;
    assign result.code_point  = entry_reg[rd_ptr_reg].cp;
    assign result.last        = entry_reg[rd_ptr_reg].last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + jsd_pkg::QUEUE_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + jsd_pkg::QUEUE_AW'(pop);
        count_next  = count_reg + push_n - jsd_pkg::QUEUE_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push && step.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= step.res0;
        end
        if (push && step.count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + jsd_pkg::QUEUE_AW'(1)] <= step.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= jsd_pkg::QUEUE_CW'(jsd_pkg::QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg <= jsd_pkg::QUEUE_CW'(jsd_pkg::QUEUE_DEPTH - 2))
        else $error("results pushed without room for two words");

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid)
        else $error("result word withdrawn while stalled");

endmodule

`default_nettype wire

FILE: hdl/json_string_body_decoder_top.sv
// json string body decoder
//
// stream: one word per byte of a quoted string, opening quote first; kind 0
// carries data_byte, kind 1 marks end of input. result: decoded code points,
// an end word at the closing quote, or an error word; last marks the final
// word caused by one input word, which causes at most two.
//
// a word taken from stream sits in the input register, is decoded from
// there and its results enter a four-word queue; the first result is
// offered from the queue once the results have been written into it.
// throughput: one input word per cycle while each causes one result and
// result does not stall; words that cause two results are held back by the
// single queue read port.
// when result stalls, the queue fills; once fewer than two free queue slots
// remain the word in the input register waits and stream.ready drops.
// reset empties the queue and the input register and puts the decoder back
// outside a string, waiting for an opening quote.
`default_nettype none

module json_string_body_decoder_top (
    input  logic      clk,
    input  logic      rst_n,
    jsd_in_if.sink    stream,
    jsd_out_if.source result
);

    logic       in_valid_reg;
    logic       in_kind_reg;
    logic [7:0] in_byte_reg;
    logic       room;
    logic       commit;
    jsd_pkg::step_t step;

    assign commit       = in_valid_reg && room;
    assign stream.ready = !in_valid_reg || commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_kind_reg <= stream.kind;
            in_byte_reg <= stream.data_byte;
        end
    end

    jsd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (commit),
        .kind      (in_kind_reg),
        .data_byte (in_byte_reg),
        .step      (step)
    );

    jsd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (commit),
        .step   (step),
        .room   (room),
        .result (result)
    );

endmodule

`default_nettype wire
